[rtl/mbe_pkg.sv]
// Shared types and constants for the Mandelbrot escape-time block.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int VIEW_W     = 32;
  localparam int SIZE_W     = 13;
  localparam int LIMIT_W    = 16;
  // width of one unsigned limb in the split z multipliers
  localparam int LIMB_W     = 34;

  localparam logic [CFG_IDX_W-1:0] CFG_REAL_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd6;

  localparam logic [VIEW_W-1:0]  RST_REAL_MIN   = 32'hE000_0000;
  localparam logic [VIEW_W-1:0]  RST_REAL_MAX   = 32'h1000_0000;
  localparam logic [VIEW_W-1:0]  RST_IMAG_MIN   = 32'hF000_0000;
  localparam logic [VIEW_W-1:0]  RST_IMAG_MAX   = 32'h1000_0000;
  localparam logic [SIZE_W-1:0]  RST_WIDTH      = 13'd300;
  localparam logic [SIZE_W-1:0]  RST_HEIGHT     = 13'd200;
  localparam logic [LIMIT_W-1:0] RST_ITER_LIMIT = 16'd256;

  typedef struct packed {
    logic capture;
    logic num_load;
    logic div_start;
    logic map_load;
    logic mul_step;
    logic z_update;
    logic out_load;
  } mbe_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_last;
    logic iter_go;
  } mbe_status_t;

endpackage

`default_nettype wire

[rtl/mbe_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; used by the datapath for the pixel-to-plane mapping.
`timescale 1ns / 1ps
`default_nettype none

module mbe_div #(
  parameter int DIVIDEND_W = 44,
  parameter int DIVISOR_W  = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  active;

  logic [DIVISOR_W:0]    rem_shift;
  logic                  ge;
  logic [DIVISOR_W:0]    rem_sub;

  always_comb begin
    rem_shift = {rem, quo[DIVIDEND_W-1]};
    ge        = rem_shift >= {1'b0, dvs};
    rem_sub   = rem_shift - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      cnt    <= CNT_W'(DIVIDEND_W);
    end else if (active && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (active && cnt != '0) begin
      quo <= {quo[DIVIDEND_W-2:0], ge};
      rem <= ge ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end
  end

  assign done     = active && cnt == '0;
  assign quotient = quo;

endmodule

`default_nettype wire

[rtl/mbe_datapath.sv]
// Datapath: view registers, coordinate mapping, z iteration with split
// multipliers, escape test and result register. Depends on mbe_pkg, mbe_div.
`timescale 1ns / 1ps
`default_nettype none

module mbe_datapath import mbe_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [COORD_BITS-1:0] pixel_x,
  input  wire logic [COORD_BITS-1:0] pixel_y,
  input  wire mbe_cmd_t              cmd,
  output mbe_status_t                status,
  output logic [COUNT_BITS-1:0]      escape_count
);

  localparam int NUM_W = VIEW_W + 2 + COORD_BITS;
  localparam int DIV_W = VIEW_W + COORD_BITS;
  localparam int VW    = DIV_W + 2;
  localparam int ZW    = (FRAC_BITS >= 30) ? FRAC_BITS + 4 : VIEW_W + 1;
  localparam int PW    = 2 * ZW;
  localparam int L     = (ZW + LIMB_W - 1) / LIMB_W;
  localparam int IW    = (L > 1) ? $clog2(L) : 1;
  localparam int LP    = 2 ** IW;
  localparam int TOP_LO = (L - 1) * LIMB_W;

  localparam logic [PW:0] RADIUS = (PW + 1)'(1) << (2 * FRAC_BITS + 2);
  localparam logic signed [VW-1:0] SAT_HI = VW'(64'sd2147483647);
  localparam logic signed [VW-1:0] SAT_LO = VW'(-64'sd2147483648);

  logic signed [VIEW_W-1:0] real_min, real_max, imag_min, imag_max;
  logic [SIZE_W-1:0]        image_width, image_height;
  logic [LIMIT_W-1:0]       iteration_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      real_min        <= RST_REAL_MIN;
      real_max        <= RST_REAL_MAX;
      imag_min        <= RST_IMAG_MIN;
      imag_max        <= RST_IMAG_MAX;
      image_width     <= RST_WIDTH;
      image_height    <= RST_HEIGHT;
      iteration_limit <= RST_ITER_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REAL_MIN:   real_min        <= cfg_data;
        CFG_REAL_MAX:   real_max        <= cfg_data;
        CFG_IMAG_MIN:   imag_min        <= cfg_data;
        CFG_IMAG_MAX:   imag_max        <= cfg_data;
        CFG_WIDTH:      image_width     <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT:     image_height    <= cfg_data[SIZE_W-1:0];
        CFG_ITER_LIMIT: iteration_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // mapping: lo + trunc(pos * (hi - lo) / size)
  logic [COORD_BITS-1:0]    px, py;
  logic signed [VIEW_W:0]   span_re, span_im;
  logic signed [NUM_W-1:0]  num_re, num_im;
  logic [DIV_W-1:0]         mag_re, mag_im;
  logic [SIZE_W-1:0]        n_re, n_im;
  logic [DIV_W-1:0]         q_re, q_im;
  logic                     done_re, done_im;
  logic signed [DIV_W:0]    qs_re, qs_im;
  logic signed [VW-1:0]     v_re, v_im;
  logic signed [VIEW_W-1:0] sat_re, sat_im;
  logic signed [VIEW_W-1:0] cr, ci;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (cmd.num_load) begin
      num_re <= span_re * $signed({1'b0, px});
      num_im <= span_im * $signed({1'b0, py});
    end
  end

  always_comb begin
    span_re = $signed({real_max[VIEW_W-1], real_max}) - $signed({real_min[VIEW_W-1], real_min});
    span_im = $signed({imag_max[VIEW_W-1], imag_max}) - $signed({imag_min[VIEW_W-1], imag_min});
    mag_re  = num_re[NUM_W-1] ? DIV_W'(-num_re) : DIV_W'(num_re);
    mag_im  = num_im[NUM_W-1] ? DIV_W'(-num_im) : DIV_W'(num_im);
    n_re    = (image_width == '0) ? SIZE_W'(1) : image_width;
    n_im    = (image_height == '0) ? SIZE_W'(1) : image_height;
    qs_re   = num_re[NUM_W-1] ? -$signed({1'b0, q_re}) : $signed({1'b0, q_re});
    qs_im   = num_im[NUM_W-1] ? -$signed({1'b0, q_im}) : $signed({1'b0, q_im});
    v_re    = VW'(real_min) + VW'(qs_re);
    v_im    = VW'(imag_min) + VW'(qs_im);
    priority if (v_re > SAT_HI) sat_re = SAT_HI[VIEW_W-1:0];
    else if (v_re < SAT_LO)     sat_re = SAT_LO[VIEW_W-1:0];
    else                        sat_re = v_re[VIEW_W-1:0];
    priority if (v_im > SAT_HI) sat_im = SAT_HI[VIEW_W-1:0];
    else if (v_im < SAT_LO)     sat_im = SAT_LO[VIEW_W-1:0];
    else                        sat_im = v_im[VIEW_W-1:0];
  end

  mbe_div #(.DIVIDEND_W(DIV_W), .DIVISOR_W(SIZE_W)) u_div_re (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag_re),
    .divisor  (n_re),
    .done     (done_re),
    .quotient (q_re)
  );

  mbe_div #(.DIVIDEND_W(DIV_W), .DIVISOR_W(SIZE_W)) u_div_im (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag_im),
    .divisor  (n_im),
    .done     (done_im),
    .quotient (q_im)
  );

  // z iteration: limb products accumulated over L*L steps
  logic signed [ZW-1:0]     zr, zi;
  logic [LIMIT_W-1:0]       count;
  logic [IW-1:0]            li, lj;
  logic signed [LIMB_W:0]   zr_limb [LP];
  logic signed [LIMB_W:0]   zi_limb [LP];

  for (genvar k = 0; k < LP; k++) begin : g_limb
    if (k < L - 1) begin : g_low
      assign zr_limb[k] = $signed({1'b0, zr[k*LIMB_W +: LIMB_W]});
      assign zi_limb[k] = $signed({1'b0, zi[k*LIMB_W +: LIMB_W]});
    end else if (k == L - 1) begin : g_top
      assign zr_limb[k] = (LIMB_W + 1)'($signed(zr[ZW-1:TOP_LO]));
      assign zi_limb[k] = (LIMB_W + 1)'($signed(zi[ZW-1:TOP_LO]));
    end else begin : g_pad
      assign zr_limb[k] = '0;
      assign zi_limb[k] = '0;
    end
  end

  logic signed [2*LIMB_W+1:0] p_rr, p_ii, p_ri;
  logic [IW:0]                lsum;
  logic                       first_step;
  logic signed [PW-1:0]       t_rr, t_ii, t_ri;
  logic signed [PW-1:0]       acc_rr, acc_ii, acc_ri;

  always_comb begin
    p_rr       = zr_limb[li] * zr_limb[lj];
    p_ii       = zi_limb[li] * zi_limb[lj];
    p_ri       = zr_limb[li] * zi_limb[lj];
    lsum       = {1'b0, li} + {1'b0, lj};
    t_rr       = PW'(p_rr) <<< (lsum * LIMB_W);
    t_ii       = PW'(p_ii) <<< (lsum * LIMB_W);
    t_ri       = PW'(p_ri) <<< (lsum * LIMB_W);
    first_step = li == '0 && lj == '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      acc_rr <= first_step ? t_rr : acc_rr + t_rr;
      acc_ii <= first_step ? t_ii : acc_ii + t_ii;
      acc_ri <= first_step ? t_ri : acc_ri + t_ri;
    end
  end

  logic [PW:0]          mag_sq;
  logic signed [PW:0]   diff_sq;
  logic signed [ZW-1:0] zr_new, zi_new;
  logic                 last_limb;

  always_comb begin
    mag_sq    = {1'b0, acc_rr} + {1'b0, acc_ii};
    diff_sq   = $signed({acc_rr[PW-1], acc_rr}) - $signed({acc_ii[PW-1], acc_ii});
    zr_new    = ZW'(diff_sq >>> FRAC_BITS) + ZW'(cr);
    zi_new    = ZW'(acc_ri >>> (FRAC_BITS - 1)) + ZW'(ci);
    last_limb = li == IW'(L - 1) && lj == IW'(L - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      li    <= '0;
      lj    <= '0;
      count <= '0;
    end else if (cmd.map_load) begin
      li    <= '0;
      lj    <= '0;
      count <= '0;
    end else begin
      if (cmd.mul_step) begin
        if (lj == IW'(L - 1)) begin
          lj <= '0;
          li <= last_limb ? '0 : li + 1'b1;
        end else begin
          lj <= lj + 1'b1;
        end
      end
      if (cmd.z_update) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_load) begin
      cr <= sat_re;
      ci <= sat_im;
      zr <= '0;
      zi <= '0;
    end else if (cmd.z_update) begin
      zr <= zr_new;
      zi <= zi_new;
    end
    if (cmd.out_load) begin
      escape_count <= COUNT_BITS'(count);
    end
  end

  assign status.div_done = done_re && done_im;
  assign status.mul_last = last_limb;
  assign status.iter_go  = (count < iteration_limit) && (mag_sq <= RADIUS);

endmodule

`default_nettype wire

[rtl/mbe_ctrl.sv]
// Controller state machine: sequences mapping, division, iteration and
// the output register handshake. Depends on mbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbe_ctrl import mbe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire mbe_status_t status,
  output mbe_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_NUM    = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_MAP    = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_UPD    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state, state_next;
  logic       m_tvalid_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_NUM;
        end
      end
      S_NUM: begin
        cmd.num_load = 1'b1;
        state_next   = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_next = S_MAP;
      end
      S_MAP: begin
        cmd.map_load = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_next = S_UPD;
      end
      S_UPD: begin
        if (status.iter_go) begin
          cmd.z_update = 1'b1;
          state_next   = S_MUL;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  assign s_tready = state == S_IDLE;

endmodule

`default_nettype wire

[rtl/mandelbrot_escape_time.sv]
// Mandelbrot escape-time unit, top level.
// Input stream: one pixel (column, row) per item. Output stream: one escape
// count per item, in input order.
// Configuration: write cfg_data to register cfg_index (0..6: real_min,
// real_max, imag_min, imag_max, image_width, image_height, iteration_limit)
// while the block is idle; indexes past the list are ignored.
// One pixel is worked at a time: the mapping division, then n + 1 passes
// of L*L multiply steps, each followed by an update step, n being the
// iterations done (at most iteration_limit) and L the limb count of the z
// multipliers (1 up to FRAC_BITS 30).
// The mapping division is bit-serial, one quotient bit a cycle.
// The next pixel is taken as soon as the previous one is in the output
// register.
// A stalled receiver holds the result in the output register; a finished
// second result waits until the first one is taken.
// Reset (rst, synchronous) clears the sequencer and output valid and
// restores the default view registers.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                 cfg_data,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // fields from bit 0: pixel_x, pixel_y, zero fill
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // fields from bit 0: escape_count, zero fill
  output logic [((COUNT_BITS+7)/8)*8-1:0]            m_tdata
);

  localparam int OUT_W = ((COUNT_BITS + 7) / 8) * 8;

  mbe_cmd_t              cmd;
  mbe_status_t           status;
  logic [COUNT_BITS-1:0] escape_count;

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mbe_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_x      (s_tdata[COORD_BITS-1:0]),
    .pixel_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .cmd          (cmd),
    .status       (status),
    .escape_count (escape_count)
  );

  assign m_tdata = OUT_W'(escape_count);

endmodule

`default_nettype wire

[rtl/mbe_checker.sv]
// Port-level checks for the escape-time top level, attached by bind.
// Sees only the stream ports of mandelbrot_escape_time.
`timescale 1ns / 1ps
`default_nettype none

module mbe_checker #(
  parameter int DATA_W = 16
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [DATA_W-1:0] m_tdata
);

  // out of reset: ready for a pixel, nothing pending
  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  // one pixel at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after accepting an item");

  // mapping runs through the number, divider start and divide states first, so no result appears right after accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared one cycle after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind mandelbrot_escape_time mbe_checker #(.DATA_W($bits(m_tdata))) u_mbe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
